@@ rtl/sliding_window_chunk_tracker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// sliding window chunk tracker assertion macros
// shared property forms for the checker that watches the tracker ports
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_CHUNK_TRACKER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_CHUNK_TRACKER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SWCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/swct_pkg.sv @@
// ----------------------------------------------------------------------------
// swct_pkg
// types and codes shared by the chunk tracker modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swct_pkg;

	localparam int SEQ_W  = 32;
	localparam int MAP_W  = 64;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 3;
	localparam int BIT_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_LOOKUP  = 2'd1,
		CMD_CAPTURE = 2'd2
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		STAT_ACCEPTED = 3'd0,
		STAT_LATE     = 3'd1,
		STAT_DUP      = 3'd2,
		STAT_PRESENT  = 3'd3,
		STAT_ABSENT   = 3'd4,
		STAT_MAP      = 3'd5
	} status_e;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [SEQ_W-1:0] seq_num;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SEQ_W-1:0]  window_start;
		logic [SEQ_W-1:0]  window_head;
		logic [MAP_W-1:0]  map_word;
		logic              last;
	} out_word_t;

endpackage

@@ rtl/sliding_window_chunk_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_chunk_tracker_unit
// receive window tracker: ring of slot tags with insert, lookup and map capture
//
// usage
//   in channel: valid/ready, one word holds a command and a sequence number
//   out channel: valid/ready, status, window start/head, map word and last
//   cfg_wr_en with cfg_wr_data loads window start and head, taken at once
//   after reset a clearing pass writes every slot invalid with in_ready
//   low; config writes are still taken during that pass
//   insert and lookup give one result each; the slot index is masked when
//   SLOTS is a power of two, otherwise it comes from a reciprocal multiply
//   with one correction
//   capture reads one slot at a time through the single ram read port and
//   gives ceil(SLOTS/64) map words, the last one marked last
//   a new word is taken only once the current item is finished
//   a word with an unknown command is taken and gives no result
//   a waiting result sits in the output register while the next word is
//   accepted; a stalled receiver holds the tracker only when a new result
//   must be written there
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_chunk_tracker_unit #(
	parameter int SLOTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [swct_pkg::SEQ_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  swct_pkg::in_word_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output swct_pkg::out_word_t        out_data
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SEQ_W  = swct_pkg::SEQ_W;
	localparam int TAG_W  = SEQ_W + 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [SEQ_W-1:0]  SLOTS_M1  = SEQ_W'(SLOTS - 1);
	localparam logic [swct_pkg::BIT_W-1:0] BIT_LAST = '1;

	// sequencer state
	swct_pkg::state_e state_q, state_d;

	// window registers
	logic [SEQ_W-1:0] start_q;
	logic [SEQ_W-1:0] head_q;

	// current item
	logic [swct_pkg::CMD_W-1:0] cmd_q;
	logic [SEQ_W-1:0]           seq_q;
	logic [SLOT_W-1:0]          slot_q;

	// insert decision terms, registered in the read cycle
	logic             late_q;
	logic             gt_head_q;
	logic             cand_ok_q;
	logic [SEQ_W-1:0] cand_q;

	// capture walk
	logic [SLOT_W-1:0]          off_q;
	logic [SEQ_W-1:0]           target_q;
	logic [swct_pkg::MAP_W-1:0] word_q;
	logic [SEQ_W-1:0]           diff_q;
	logic                       neg_q;

	// output register
	logic                out_valid_q;
	swct_pkg::out_word_t out_data_q;

	// ram and modulo unit
	logic              ram_we;
	logic [TAG_W-1:0]  ram_wdata;
	logic [TAG_W-1:0]  ram_rdata;
	logic              rd_valid;
	logic [SEQ_W-1:0]  rd_tag;
	logic              mod_start;
	logic [SEQ_W-1:0]  mod_operand;
	logic              mod_done;
	logic [SLOT_W-1:0] mod_rem;

	// combinational terms
	logic                       in_fire;
	logic                       cmd_known;
	logic                       out_free;
	logic                       last_off;
	logic                       span_ok;
	logic                       seq_hit;
	logic                       cap_hit;
	logic                       emit_word;
	logic [swct_pkg::MAP_W-1:0] map_next;
	logic [SEQ_W-1:0]           new_start;
	logic [SEQ_W-1:0]           new_head;
	logic                       res_load;
	swct_pkg::out_word_t        res;
	logic                       chk_go;
	logic                       ins_commit;

	swct_ram #(
		.WIDTH (TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (ram_wdata),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	swct_mod #(
		.DIVISOR (SLOTS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.operand (mod_operand),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign rd_valid = ram_rdata[TAG_W-1];
	assign rd_tag   = ram_rdata[SEQ_W-1:0];

	assign in_ready  = (state_q == swct_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cmd_known = (in_data.command == swct_pkg::CMD_INSERT)
		|| (in_data.command == swct_pkg::CMD_LOOKUP)
		|| (in_data.command == swct_pkg::CMD_CAPTURE);
	assign out_free  = !out_valid_q || out_ready;

	// capture: capture reduces start_q, insert and lookup the sequence number
	assign mod_operand = (in_data.command == swct_pkg::CMD_CAPTURE) ? start_q : in_data.seq_num;

	// a slot matches only when valid and carrying the exact tag
	assign seq_hit = rd_valid && (rd_tag == seq_q);
	assign cap_hit = span_ok && rd_valid && (rd_tag == target_q);

	// offset inside [0, head - start], nothing when head is below start
	assign span_ok   = !neg_q && (SEQ_W'(off_q) <= diff_q);
	assign last_off  = (off_q == SLOT_LAST);
	assign emit_word = (off_q[swct_pkg::BIT_W-1:0] == BIT_LAST) || last_off;
	assign map_next  = word_q | (swct_pkg::MAP_W'(cap_hit) << off_q[swct_pkg::BIT_W-1:0]);

	// window update of an accepted insert
	assign new_head  = gt_head_q ? seq_q : head_q;
	assign new_start = (gt_head_q && cand_ok_q && (cand_q > start_q)) ? cand_q : start_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swct_pkg::S_CLEAR: begin
				if (slot_q == SLOT_LAST) begin
					state_d = swct_pkg::S_IDLE;
				end
			end
			swct_pkg::S_IDLE: begin
				if (in_fire && cmd_known) begin
					state_d = swct_pkg::S_MOD;
				end
			end
			swct_pkg::S_MOD: begin
				if (mod_done) begin
					state_d = swct_pkg::S_READ;
				end
			end
			swct_pkg::S_READ: begin
				state_d = swct_pkg::S_CHECK;
			end
			swct_pkg::S_CHECK: begin
				if (chk_go) begin
					if ((cmd_q == swct_pkg::CMD_CAPTURE) && !last_off) begin
						state_d = swct_pkg::S_READ;
					end else begin
						state_d = swct_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = swct_pkg::S_IDLE;
			end
		endcase
	end

	// control outputs and result word
	always_comb begin
		ram_we     = 1'b0;
		ram_wdata  = '0;
		mod_start  = 1'b0;
		res_load   = 1'b0;
		chk_go     = 1'b0;
		ins_commit = 1'b0;
		res.status       = swct_pkg::STAT_ACCEPTED;
		res.window_start = start_q;
		res.window_head  = head_q;
		res.map_word     = '0;
		res.last         = 1'b1;
		unique case (state_q)
			swct_pkg::S_CLEAR: begin
				// invalidate one slot per cycle
				ram_we = 1'b1;
			end
			swct_pkg::S_IDLE: begin
				mod_start = in_fire && cmd_known;
			end
			swct_pkg::S_MOD, swct_pkg::S_READ: begin
				ram_we = 1'b0;
			end
			swct_pkg::S_CHECK: begin
				unique case (cmd_q)
					swct_pkg::CMD_INSERT: begin
						chk_go   = out_free;
						res_load = out_free;
						priority if (late_q) begin
							res.status = swct_pkg::STAT_LATE;
						end else if (seq_hit) begin
							res.status = swct_pkg::STAT_DUP;
						end else begin
							res.status       = swct_pkg::STAT_ACCEPTED;
							res.window_start = new_start;
							res.window_head  = new_head;
							ins_commit       = out_free;
							ram_we           = out_free;
							ram_wdata        = {1'b1, seq_q};
						end
					end
					swct_pkg::CMD_LOOKUP: begin
						chk_go     = out_free;
						res_load   = out_free;
						res.status = seq_hit ? swct_pkg::STAT_PRESENT : swct_pkg::STAT_ABSENT;
					end
					swct_pkg::CMD_CAPTURE: begin
						// a finished word waits for room in the output register
						chk_go       = !emit_word || out_free;
						res_load     = emit_word && out_free;
						res.status   = swct_pkg::STAT_MAP;
						res.map_word = map_next;
						res.last     = last_off;
					end
					default: begin
						chk_go = 1'b1;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swct_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			start_q     <= '0;
			head_q      <= '0;
		end else begin
			state_q <= state_d;

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// slot pointer doubles as the clearing address
			if (state_q == swct_pkg::S_CLEAR) begin
				slot_q <= slot_q + 1'b1;
			end else if ((state_q == swct_pkg::S_MOD) && mod_done) begin
				slot_q <= mod_rem;
			end else if ((state_q == swct_pkg::S_CHECK) && (cmd_q == swct_pkg::CMD_CAPTURE)
					&& chk_go && !last_off) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end

			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
				head_q  <= cfg_wr_data;
			end else if (ins_commit) begin
				start_q <= new_start;
				head_q  <= new_head;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= res;
		end

		if (in_fire) begin
			cmd_q    <= in_data.command;
			seq_q    <= in_data.seq_num;
			off_q    <= '0;
			target_q <= start_q;
			word_q   <= '0;
		end else if ((state_q == swct_pkg::S_CHECK) && (cmd_q == swct_pkg::CMD_CAPTURE)
				&& chk_go) begin
			off_q    <= off_q + 1'b1;
			target_q <= target_q + 1'b1;
			word_q   <= emit_word ? '0 : map_next;
		end

		if (state_q == swct_pkg::S_MOD) begin
			diff_q <= head_q - start_q;
			neg_q  <= (head_q < start_q);
		end

		// insert terms, ready when the tag comes back
		if (state_q == swct_pkg::S_READ) begin
			late_q    <= (seq_q < start_q);
			gt_head_q <= (seq_q > head_q);
			cand_ok_q <= (seq_q >= SLOTS_M1);
			cand_q    <= seq_q - SLOTS_M1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/swct_ram.sv @@
// ----------------------------------------------------------------------------
// swct_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swct_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/swct_mod.sv @@
// ----------------------------------------------------------------------------
// swct_mod
// sequence number to slot index reduction, masked or by reciprocal multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swct_mod #(
	parameter int DIVISOR = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swct_pkg::SEQ_W-1:0] operand,
	output logic                       done,
	output logic [$clog2(DIVISOR)-1:0] rem
);

	localparam int SEQ_W = swct_pkg::SEQ_W;
	localparam int REM_W = $clog2(DIVISOR);
	localparam int RCP_W = SEQ_W - REM_W + 1;
	localparam bit POW2  = ((DIVISOR & (DIVISOR - 1)) == 0);
	// floor(2^32 / DIVISOR): the quotient estimate is the true one or one below
	localparam logic [RCP_W-1:0] RCP   = RCP_W'((64'd1 << SEQ_W) / DIVISOR);
	localparam logic [SEQ_W-1:0] DIV_L = SEQ_W'(DIVISOR);

	logic                     vld_s1;
	logic                     vld_s2;
	logic                     done_q;
	logic [SEQ_W+RCP_W-1:0]   prod_s1;
	logic [SEQ_W-1:0]         qs_s2;
	logic [SEQ_W-1:0]         opd_q;
	logic [REM_W-1:0]         rem_q;
	logic [RCP_W-1:0]         q_est;
	logic [SEQ_W-1:0]         diff;
	logic [SEQ_W-1:0]         rem_fix;

	assign q_est   = prod_s1[SEQ_W+RCP_W-1:SEQ_W];
	assign diff    = opd_q - qs_s2;
	// one correction step covers an estimate that is one too small
	assign rem_fix = (diff >= DIV_L) ? (diff - DIV_L) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !POW2;
			vld_s2 <= vld_s1;
			done_q <= (start && POW2) || vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			opd_q   <= operand;
			prod_s1 <= {{RCP_W{1'b0}}, operand} * {{SEQ_W{1'b0}}, RCP};
		end

		if (vld_s1) begin
			qs_s2 <= {{(SEQ_W-RCP_W){1'b0}}, q_est} * DIV_L;
		end

		if (start && POW2) begin
			rem_q <= operand[REM_W-1:0];
		end else if (vld_s2) begin
			rem_q <= rem_fix[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ rtl/swct_chk.sv @@
// ----------------------------------------------------------------------------
// swct_chk
// port level checks of the chunk tracker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sliding_window_chunk_tracker_unit_macros.svh"

module swct_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input swct_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input swct_pkg::out_word_t out_data
);

	logic not_map;
	logic known_fire;

	assign not_map    = (out_data.status != swct_pkg::STAT_MAP);
	assign known_fire = in_valid && in_ready
		&& ((in_data.command == swct_pkg::CMD_INSERT)
		|| (in_data.command == swct_pkg::CMD_LOOKUP)
		|| (in_data.command == swct_pkg::CMD_CAPTURE));

	// a stalled result word stays put
	`SWCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

	// only map words carry presence bits
	`SWCT_ASSERT_SAME(a_map_zero, clk, arst_n, out_valid && not_map, out_data.map_word == '0, "map bits on a non-map word")

	// insert and lookup give a single word, so it closes the item
	`SWCT_ASSERT_SAME(a_single_last, clk, arst_n, out_valid && not_map, out_data.last, "single result without last")

	// the window never turns over: start stays at or below head
	`SWCT_ASSERT_SAME(a_window_order, clk, arst_n, out_valid, out_data.window_head >= out_data.window_start, "window head below start")

	// a taken command word keeps the input closed while it is worked on
	`SWCT_ASSERT_NEXT(a_busy_after_take, clk, arst_n, known_fire, !in_ready, "input open right after a command word")

endmodule

bind sliding_window_chunk_tracker_unit swct_chk u_swct_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ tb/sliding_window_chunk_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sliding window chunk tracker testbench
// drives insert, lookup and capture words through the tracker with bursty
// input and a stalling receiver, predicts every result word from a private
// copy of the slot ring and the window, and checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class chunk_window_ledger #(int RING = 256);

	localparam int MAP_WORDS = (RING + 63) / 64;

	bit                      slot_valid[RING];
	logic [31:0]             slot_tag[RING];
	logic [31:0]             win_start;
	logic [31:0]             win_head;
	swct_pkg::out_word_t     owed_words[$];
	int                      errors;

	function new();
		foreach (slot_valid[k]) begin
			slot_valid[k] = 1'b0;
			slot_tag[k]   = '0;
		end
		win_start = '0;
		win_head  = '0;
		errors    = 0;
	endfunction

	function void load_start(logic [31:0] value);
		win_start = value;
		win_head  = value;
	endfunction

	function int pending();
		return owed_words.size();
	endfunction

	function bit holds_seq(logic [31:0] seq);
		int unsigned s;
		s = seq % RING;
		return slot_valid[s] && (slot_tag[s] == seq);
	endfunction

	function void owe_word(swct_pkg::status_e st, logic [63:0] bits, bit fin);
		swct_pkg::out_word_t r;
		r.status       = st;
		r.window_start = win_start;
		r.window_head  = win_head;
		r.map_word     = bits;
		r.last         = fin;
		owed_words = {owed_words, r};
	endfunction

	function void note_word(swct_pkg::in_word_t w);
		logic [31:0] seq;
		logic [32:0] span;
		logic [32:0] idx;
		logic [32:0] cand;
		logic [63:0] bits;
		int unsigned s;
		seq = w.seq_num;
		case (w.command)
			swct_pkg::CMD_INSERT: begin
				if (seq < win_start)
					owe_word(swct_pkg::STAT_LATE, '0, 1'b1);
				else if (holds_seq(seq))
					owe_word(swct_pkg::STAT_DUP, '0, 1'b1);
				else begin
					s = seq % RING;
					slot_valid[s] = 1'b1;
					slot_tag[s]   = seq;
					if (seq > win_head) begin
						win_head = seq;
						if ({1'b0, seq} + 33'd1 >= 33'(RING)) begin
							cand = {1'b0, seq} + 33'd1 - 33'(RING);
							if (cand[31:0] > win_start)
								win_start = cand[31:0];
						end
					end
					owe_word(swct_pkg::STAT_ACCEPTED, '0, 1'b1);
				end
			end
			swct_pkg::CMD_LOOKUP: begin
				owe_word(holds_seq(seq) ? swct_pkg::STAT_PRESENT : swct_pkg::STAT_ABSENT,
					'0, 1'b1);
			end
			swct_pkg::CMD_CAPTURE: begin
				span = (win_head >= win_start) ? {1'b0, win_head - win_start} + 33'd1 : '0;
				for (int wd = 0; wd < MAP_WORDS; wd++) begin
					bits = '0;
					for (int b = 0; b < 64; b++) begin
						idx = 33'(wd * 64 + b);
						if (idx < span && idx < 33'(RING) && holds_seq(win_start + idx[31:0]))
							bits[b] = 1'b1;
					end
					owe_word(swct_pkg::STAT_MAP, bits, wd == MAP_WORDS - 1);
				end
			end
			default: ;
		endcase
	endfunction

	task report(string what);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", what);
	endtask

	task check_word(swct_pkg::out_word_t got);
		swct_pkg::out_word_t want;
		if (owed_words.size() == 0) begin
			report($sformatf("result word with nothing owed, status %0d", got.status));
			return;
		end
		want = owed_words.pop_front();
		if (got.status !== want.status)
			report($sformatf("status %0d, wanted %0d", got.status, want.status));
		if (got.window_start !== want.window_start)
			report($sformatf("window_start %h, wanted %h", got.window_start,
				want.window_start));
		if (got.window_head !== want.window_head)
			report($sformatf("window_head %h, wanted %h", got.window_head,
				want.window_head));
		if (got.map_word !== want.map_word)
			report($sformatf("map_word %h, wanted %h", got.map_word, want.map_word));
		if (got.last !== want.last)
			report($sformatf("last %b, wanted %b", got.last, want.last));
	endtask

endclass

module sliding_window_chunk_tracker_unit_tb;

	localparam int          SLOTS          = 256;
	localparam int          IDLE_HOLD      = 48;     // covers the slowest word with no result
	localparam int          END_HOLD       = 64;
	localparam int          WATCHDOG_LIMIT = 5000;   // capture is the longest item
	localparam logic [1:0]  CMD_IGNORED    = 2'd3;
	localparam logic [31:0] SEQ_TOP        = 32'hFFFF_FFFF;
	localparam logic [31:0] START_NEAR_TOP = 32'hFFFF_FE00;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [31:0]         cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	swct_pkg::in_word_t  in_data;
	logic                out_valid;
	logic                out_ready;
	swct_pkg::out_word_t out_data;

	chunk_window_ledger #(SLOTS) ledger;
	int burst_left;
	int quiet_cycles = 0;

	sliding_window_chunk_tracker_unit #(
		.SLOTS(SLOTS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// both channels are sampled at the rising edge; the ledger learns each
	// accepted word and checks each delivered result word in order
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			ledger.note_word(in_data);
		if (arst_n && out_valid && out_ready)
			ledger.check_word(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// nothing moving on either channel for too long means the tracker hung
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// receiver: stretches of steady ready, random stalls, a rotating pattern
	// and full stalls
	initial begin
		int mode;
		int left;
		logic [7:0] stall_pattern;
		out_ready = 1'b0;
		mode = 0;
		left = 0;
		stall_pattern = 8'hFF;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = (mode == 3) ? $urandom_range(4, 20) : $urandom_range(8, 48);
				stall_pattern = $urandom;
			end
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= stall_pattern[left % 8];
				default: out_ready <= 1'b0;
			endcase
			left--;
		end
	end

	function automatic swct_pkg::in_word_t chunk_word(logic [1:0] cmd, logic [31:0] seq);
		swct_pkg::in_word_t w;
		w.command = cmd;
		w.seq_num = seq;
		return w;
	endfunction

	// random word shaped around the current window: mostly head advances,
	// in-window fills and repeats, with late words, lookups, captures and noise
	function automatic swct_pkg::in_word_t pick_chunk_word();
		int unsigned roll;
		logic [31:0] reach;
		logic [31:0] head;
		logic [31:0] start;
		head  = ledger.win_head;
		start = ledger.win_start;
		reach = (head >= start) ? head - start : '0;
		if (reach > 32'd255)
			reach = 32'd255;
		roll = $urandom_range(0, 99);
		if (roll < 42)
			return chunk_word(swct_pkg::CMD_INSERT, head + $urandom_range(1, 8));
		else if (roll < 58)
			return chunk_word(swct_pkg::CMD_INSERT, start + $urandom_range(0, reach));
		else if (roll < 66)
			return chunk_word(swct_pkg::CMD_INSERT, head - $urandom_range(0, 6));
		else if (roll < 71)
			return chunk_word(swct_pkg::CMD_INSERT,
				(start != 0) ? start - $urandom_range(1, 300) : head);
		else if (roll < 87)
			return chunk_word(swct_pkg::CMD_LOOKUP, head - $urandom_range(0, 300));
		else if (roll < 92)
			return chunk_word(swct_pkg::CMD_CAPTURE, $urandom);
		else if (roll < 95)
			return chunk_word(CMD_IGNORED, $urandom);
		else
			return chunk_word(2'($urandom_range(0, 1)), $urandom);
	endfunction

	// sender: bursts of back-to-back words with random gaps between bursts;
	// a random word is picked at the falling edge so the ledger is current
	task automatic drive_word(input swct_pkg::in_word_t w, input bit pick);
		int gap;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		if (pick)
			w = pick_chunk_word();
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
		burst_left--;
	endtask

	// stop sending and wait for every owed result word, then hold a while
	task automatic settle(input int hold);
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (hold) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_start(input logic [31:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		ledger.load_start(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int count, input int pause_at);
		for (int k = 0; k < count; k++) begin
			// one pause mid-phase until the tracker has drained
			if (k == pause_at)
				settle(0);
			drive_word('0, 1'b1);
		end
	endtask

	initial begin
		ledger      = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		burst_left  = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// window from zero; the clearing pass holds in_ready low meanwhile
		write_start(32'd0);
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, 32'd0), 1'b0);     // empty ring
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd0), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd0), 1'b0);     // duplicate
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, 32'd0), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd254), 1'b0);   // just short of a full ring
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd255), 1'b0);   // full ring, start stays 0
		drive_word(chunk_word(swct_pkg::CMD_CAPTURE, 32'd0), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd300), 1'b0);   // start pushed to 45
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd10), 1'b0);    // late
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd44), 1'b0);    // one below start
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd45), 1'b0);    // exactly at start
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'd301), 1'b0);   // same slot, new tag
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, 32'd45), 1'b0);    // stale tag
		drive_word(chunk_word(swct_pkg::CMD_CAPTURE, 32'd0), 1'b0);
		drive_word(chunk_word(CMD_IGNORED, SEQ_TOP), 1'b0);            // no result
		drive_word(chunk_word(swct_pkg::CMD_INSERT, SEQ_TOP), 1'b0);   // head to the top
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'hFFFF_FEFF), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, SEQ_TOP), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_CAPTURE, SEQ_TOP), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, 32'hFFFF_FF00), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, 32'hAAAA_AAAA), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, 32'h5555_5555), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_CAPTURE, 32'h5555_5555), 1'b0);
		drive_word(chunk_word(CMD_IGNORED, 32'd0), 1'b0);

		// random start, slots keep what earlier phases left
		settle(IDLE_HOLD);
		write_start($urandom);
		run_random(80, 40);

		// start close to the top of the sequence space
		settle(IDLE_HOLD);
		write_start(START_NEAR_TOP);
		run_random(60, -1);

		// start at the very top: nearly everything is late
		settle(IDLE_HOLD);
		write_start(SEQ_TOP);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, SEQ_TOP - 32'd1), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_INSERT, SEQ_TOP), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_LOOKUP, SEQ_TOP), 1'b0);
		drive_word(chunk_word(swct_pkg::CMD_CAPTURE, 32'd0), 1'b0);
		run_random(15, -1);

		// back to zero over a ring full of stale tags
		settle(IDLE_HOLD);
		write_start(32'd0);
		run_random(60, -1);

		settle(END_HOLD);
		if (ledger.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
